>>> sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> sv/ddm_pkg.sv
package ddm_pkg;

  localparam int NUM_MULT = 9;
  localparam int MULT_W   = 36;

  typedef struct packed {
    logic [2:0][3:0] digit;
    logic [1:0]      ndig;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic reducing;
  } back_status_t;

  function automatic cmd_t split_byte(input logic [7:0] b, input logic last);
    cmd_t       c;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [7:0] r2;
    logic [7:0] r1;
    c   = '0;
    hun = (b >= 8'd200) ? 4'd2 : ((b >= 8'd100) ? 4'd1 : 4'd0);
    unique case (hun)
      4'd2:    r2 = b - 8'd200;
      4'd1:    r2 = b - 8'd100;
      default: r2 = b;
    endcase
    ten = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (r2 >= 8'(j * 10)) ten = 4'(j);
    end
    r1 = r2 - 8'(ten) * 8'd10;
    c.last = last;
    if (b >= 8'd100) begin
      c.ndig     = 2'd3;
      c.digit[0] = hun;
      c.digit[1] = ten;
      c.digit[2] = r1[3:0];
    end else if (b >= 8'd10) begin
      c.ndig     = 2'd2;
      c.digit[0] = ten;
      c.digit[1] = r1[3:0];
    end else begin
      c.ndig     = 2'd1;
      c.digit[0] = r1[3:0];
    end
    return c;
  endfunction

endpackage

>>> sv/ddm_fifo.sv
module ddm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem;
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/ddm_front.sv
module ddm_front (
  input  logic          hash_byte_v,
  input  logic [7:0]    hash_byte,
  input  logic          last_byte,
  input  logic          cmd_full,
  output logic          full,
  output logic          cmd_push,
  output ddm_pkg::cmd_t cmd
);
  import ddm_pkg::*;

  // byte -> up to three decimal digits, most significant first
  assign cmd      = split_byte(hash_byte, last_byte);
  assign cmd_push = hash_byte_v && !cmd_full;
  assign full     = cmd_full;

endmodule

>>> sv/ddm_back.sv
module ddm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  modulus_we,
  input  logic [31:0]           modulus_in,
  input  logic                  cmd_empty,
  input  ddm_pkg::cmd_t         cmd,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [31:0]           res_data,
  output ddm_pkg::back_status_t status
);
  import ddm_pkg::*;

  localparam logic [1:0] ST_PREP   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0]                         state;
  logic [31:0]                        modulus;
  logic [NUM_MULT-1:0][MULT_W-1:0]    mult;
  logic [3:0]                         prep_cnt;
  logic [31:0]                        rem;
  logic [31:0]                        src;
  logic [4:0]                         div_cnt;
  logic [1:0]                         dig_idx;

  logic [MULT_W-1:0] wide;
  logic [MULT_W-1:0] sub;
  logic [MULT_W-1:0] diff;
  logic [31:0]       step;
  logic [32:0]       trial;
  logic [32:0]       trial_sub;
  logic              digit_last;
  logic              emit;
  logic              stall;
  logic              advance;

  // r*10 + d, then subtract the largest multiple k*m not above it (k = 0..9)
  always_comb begin
    wide = ({4'b0, rem} << 3) + ({4'b0, rem} << 1)
         + {{(MULT_W - 4){1'b0}}, cmd.digit[dig_idx]};
    sub = '0;
    for (int j = 0; j < NUM_MULT; j++) begin
      if (wide >= mult[j]) sub = mult[j];
    end
    diff = wide - sub;
    step = (modulus == '0) ? wide[31:0] : diff[31:0];
  end

  // one bit per cycle of rem mod m after a modulus change
  assign trial     = {rem, src[31]};
  assign trial_sub = trial - {1'b0, modulus};

  assign digit_last = (dig_idx == (cmd.ndig - 2'd1));
  assign emit       = digit_last && cmd.last;
  assign stall      = emit && res_full;
  assign advance    = (state == ST_RUN) && !cmd_empty && !stall;
  assign cmd_pop    = advance && digit_last;
  assign res_push   = advance && emit;
  assign res_data   = step;

  assign status.running  = (state == ST_RUN);
  assign status.reducing = (state == ST_REDUCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_PREP;
      modulus  <= 32'd1;
      mult[0]  <= MULT_W'(1);
      prep_cnt <= 4'd1;
      rem      <= '0;
      dig_idx  <= '0;
      div_cnt  <= '0;
    end else if (modulus_we) begin
      state    <= ST_PREP;
      modulus  <= modulus_in;
      mult[0]  <= {4'b0, modulus_in};
      prep_cnt <= 4'd1;
      dig_idx  <= '0;
    end else begin
      unique case (state)
        ST_PREP: begin
          mult[prep_cnt] <= mult[prep_cnt - 4'd1] + {4'b0, modulus};
          prep_cnt       <= prep_cnt + 4'd1;
          if (prep_cnt == 4'(NUM_MULT - 1)) begin
            if (modulus == '0) begin
              state <= ST_RUN;
            end else begin
              src     <= rem;
              rem     <= '0;
              div_cnt <= '0;
              state   <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          rem     <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
          src     <= src << 1;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance) begin
            rem     <= emit ? '0 : step;
            dig_idx <= digit_last ? 2'd0 : dig_idx + 2'd1;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

>>> sv/decimal_digest_modulo_unit.sv
// Decimal digest modulo unit: maps a digest, one byte per request, to a bucket index.
// Input queue: drive hash_byte/last_byte with push; a request is taken when push is
//   high and full is low. Each byte counts as its decimal digits (one to three).
// Result queue: bucket_index is valid while empty is low; pop takes it. One result
//   comes out per byte marked last_byte; the running remainder then restarts at zero.
// Configuration: modulus_we writes modulus at once (zero means 2^32).
// Throughput: the digit engine folds one decimal digit into the remainder each cycle
//   while it runs, has a byte queued and is not held by a full result queue.
// Results: a result is pushed into the result queue in the cycle that the engine
//   folds the last digit of its last byte.
// Reset and modulus writes: the engine first builds the multiples 1..9 of the
//   modulus, then reduces the held remainder one bit a cycle (skipped for modulus
//   zero). Bytes are queued meanwhile until the input queue fills.
// Stall: if pop stays low the result queue fills, the engine halts at the next
//   last byte, the input queue fills and full rises; nothing is lost.
`include "assert_macros.svh"

module decimal_digest_modulo_unit #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  hash_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] bucket_index,
  input  logic        modulus_we,
  input  logic [31:0] modulus
);
  import ddm_pkg::*;

  cmd_t         cmd_in;
  cmd_t         cmd_q;
  logic         cmd_push;
  logic         cmd_full;
  logic         cmd_empty;
  logic         cmd_pop;
  logic         res_push;
  logic         res_full;
  logic [31:0]  res_data;
  back_status_t back_status;

  ddm_front u_front (
    .hash_byte_v (push),
    .hash_byte   (hash_byte),
    .last_byte   (last_byte),
    .cmd_full    (cmd_full),
    .full        (full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  ddm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_q),
    .empty   (cmd_empty)
  );

  ddm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .modulus_we (modulus_we),
    .modulus_in (modulus),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_q),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data),
    .status     (back_status)
  );

  ddm_fifo #(
    .WIDTH (32),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (pop),
    .rd_data (bucket_index),
    .empty   (empty)
  );

  `ASSERT_IMPL(a_res_on_last, clk, rst, res_push, cmd_q.last && !res_full && !cmd_empty)
  `ASSERT_IMPL(a_pop_running, clk, rst, cmd_pop, back_status.running && !cmd_empty)
  `ASSERT_NEXT(a_cfg_restart, clk, rst, modulus_we, !back_status.running && !back_status.reducing)

endmodule

>>> verif/decimal_digest_modulo_unit_tb.sv
`timescale 1ns / 100ps

module decimal_digest_modulo_unit_tb;

  localparam int          SETTLE_CYCLES = 80;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          MAX_REPORTS   = 50;
  localparam logic [31:0] MODULUS_RESET = 32'd1;
  localparam logic [31:0] MODULUS_WRAP  = 32'd0;
  localparam logic [31:0] MODULUS_MAX   = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst          = 1'b1;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  hash_byte    = 8'd0;
  logic        last_byte    = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [31:0] bucket_index;
  logic        modulus_we   = 1'b0;
  logic [31:0] modulus      = 32'd0;

  logic [31:0] bucket_modulus = MODULUS_RESET;
  logic [31:0] digest_rem     = 32'd0;
  logic [31:0] pending_buckets[$];

  int send_idle_pct  = 28;
  int recv_idle_pct  = 46;
  int hold_requests  = 0;
  int holds_served   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  logic [7:0] edge_bytes[8] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255};

  decimal_digest_modulo_unit uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .hash_byte   (hash_byte),
    .last_byte   (last_byte),
    .empty       (empty),
    .pop         (pop),
    .bucket_index(bucket_index),
    .modulus_we  (modulus_we),
    .modulus     (modulus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] fold_digit(input logic [31:0] r, input logic [3:0] d);
    logic [63:0] wide;
    wide = {32'd0, r} * 64'd10 + {60'd0, d};
    if (bucket_modulus == MODULUS_WRAP) return wide[31:0];
    return 32'(wide % {32'd0, bucket_modulus});
  endfunction

  function automatic logic [31:0] fold_byte(input logic [31:0] r, input logic [7:0] b);
    logic [31:0] acc;
    acc = r;
    if (b >= 8'd100) acc = fold_digit(acc, 4'(b / 8'd100));
    if (b >= 8'd10) acc = fold_digit(acc, 4'((b / 8'd10) % 8'd10));
    return fold_digit(acc, 4'(b % 8'd10));
  endfunction

  function automatic logic [7:0] random_byte();
    if ($urandom_range(3) == 0) return edge_bytes[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] random_modulus();
    case ($urandom_range(7))
      0: return MODULUS_WRAP;
      1: return MODULUS_RESET;
      2: return MODULUS_MAX;
      3: return 32'($urandom_range(20, 2));
      4: return 32'($urandom_range(100000, 21));
      5: return 32'h8000_0000 + 32'($urandom_range(1000));
      default: return 32'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // one request; push stays high on return so back-to-back requests need no gap
  task automatic push_byte(input logic [7:0] b, input logic lst);
    logic [31:0] next_rem;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    hash_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    next_rem = fold_byte(digest_rem, b);
    if (lst) begin
      pending_buckets.push_back(next_rem);
      digest_rem = 32'd0;
    end else begin
      digest_rem = next_rem;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [31:0] v);
    modulus_we <= 1'b1;
    modulus    <= v;
    @(posedge clk);
    modulus_we <= 1'b0;
    bucket_modulus = v;
  endtask

  task automatic push_digest(input int len);
    for (int i = 0; i < len; i++) push_byte(random_byte(), i == len - 1);
  endtask

  // modulus left at reset value: every bucket is zero
  task automatic test_reset_modulus();
    push_byte(8'd255, 1'b0);
    push_byte(8'd0, 1'b1);
    push_byte(8'd7, 1'b1);
    wait_idle();
  endtask

  // one, two and three digit bytes, each as its own digest
  task automatic test_digit_counts();
    write_modulus(32'd7);
    foreach (edge_bytes[i]) push_byte(edge_bytes[i], 1'b1);
    wait_idle();
  endtask

  task automatic test_wide_modulus();
    write_modulus(MODULUS_MAX);
    push_byte(8'd255, 1'b0);
    push_byte(8'd128, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd254, 1'b1);
    wait_idle();
    // zero means 2^32: remainder just wraps
    write_modulus(MODULUS_WRAP);
    for (int i = 0; i < 6; i++) push_byte(8'd255, i == 5);
    wait_idle();
  endtask

  // large remainder, built under modulus zero, held across a write to a small modulus
  task automatic test_modulus_change_mid_digest();
    for (int i = 0; i < 3; i++) push_byte(8'd255, 1'b0);
    wait_idle();
    write_modulus(32'd7);
    push_byte(8'd3, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 16; i++) push_byte(random_byte(), 1'b1);
    push_digest(20);
    wait_idle();
  endtask

  task automatic test_random_digests(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        wait_idle();
        write_modulus(random_modulus());
      end
      case ($urandom_range(9))
        0, 1, 2: len = 20;
        3, 4:    len = 32;
        default: len = $urandom_range(6, 1);
      endcase
      if ($urandom_range(9) == 0) begin
        // split the digest across a modulus write
        push_digest_part(len / 2 + 1, len);
      end else begin
        push_digest(len);
      end
      sent += len;
    end
    wait_idle();
  endtask

  task automatic push_digest_part(input int head, input int len);
    for (int i = 0; i < head - 1; i++) push_byte(random_byte(), 1'b0);
    wait_idle();
    write_modulus(random_modulus());
    for (int i = head - 1; i < len; i++) push_byte(random_byte(), i == len - 1);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && pop && !empty) begin
      if (pending_buckets.size() == 0) begin
        report_mismatch($sformatf("bucket_index %0d with none pending", bucket_index));
      end else begin
        if (bucket_index !== pending_buckets[0])
          report_mismatch($sformatf("bucket_index %0d, want %0d", bucket_index,
                                    pending_buckets[0]));
        void'(pending_buckets.pop_front());
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_modulus();
    test_digit_counts();
    test_wide_modulus();
    test_modulus_change_mid_digest();
    test_backpressure();
    test_random_digests(650);
    send_idle_pct = 46;
    recv_idle_pct = 28;
    test_random_digests(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_digests(650);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
